>>> design/fir_decimator_iq_assert.svh
// Assertion macros shared by the filter modules.
`ifndef FIR_DECIMATOR_IQ_ASSERT_SVH
`define FIR_DECIMATOR_IQ_ASSERT_SVH

// Antecedent implies consequent in the same cycle, masked during reset.
`define FDI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition must never hold, masked during reset.
`define FDI_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

>>> design/fdi_pkg.sv
package fdi_pkg;

   // Sizing
   localparam int MAX_TAPS    = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
   localparam int TAP_CNT_W   = $clog2(MAX_TAPS + 1);
   localparam int DECIM_MAX   = 64;
   localparam int PHASE_W     = $clog2(DECIM_MAX);
   localparam int DECIM_CNT_W = $clog2(DECIM_MAX + 1);
   localparam int PROD_W      = 2 * SAMPLE_BITS;
   localparam int ACC_W       = PROD_W + TAP_IDX_W;

   // Field and register widths
   localparam int CMD_W       = 2;
   localparam int TAP_SEL_W   = 6;
   localparam int DECIM_W     = 7;
   localparam int TAPS_W      = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH     = 2'd0,
      CMD_LOAD_TAP = 2'd1,
      CMD_RESTART  = 2'd2
   } cmd_type;

   // Register indexes on the register port (byte address = 4 * index)
   typedef enum logic [1:0] {
      REG_DECIMATION = 2'd0,
      REG_TAPS       = 2'd1,
      REG_IQ_ENABLE  = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [DECIM_W-1:0] decimation_factor;
      logic [TAPS_W-1:0]  taps_in_use;
      logic               iq_enable;
   } cfg_type;

   // Memory port requests from the sequencer
   typedef struct packed {
      logic                          coef_we;
      logic [TAP_IDX_W-1:0]          coef_waddr;
      logic signed [SAMPLE_BITS-1:0] coef_wdata;
      logic [TAP_IDX_W-1:0]          coef_raddr;
      logic                          hist_we;
      logic [TAP_IDX_W-1:0]          hist_waddr;
      logic signed [SAMPLE_BITS-1:0] hist_wdata_i;
      logic signed [SAMPLE_BITS-1:0] hist_wdata_q;
      logic [TAP_IDX_W-1:0]          hist_raddr;
   } mem_req_type;

   // Tag travelling with each tap read
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

>>> design/fdi_ram.sv
module fdi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/fdi_mac.sv
`include "fir_decimator_iq_assert.svh"

module fdi_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fdi_pkg::mac_ctl_type                  ctl,
   input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] coef,
   input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] hist_i,
   input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] hist_q,
   output logic                                  done,
   output logic signed [fdi_pkg::SAMPLE_BITS-1:0] res_i,
   output logic signed [fdi_pkg::SAMPLE_BITS-1:0] res_q
);

   localparam int S      = fdi_pkg::SAMPLE_BITS;
   localparam int P_W    = fdi_pkg::PROD_W;
   localparam int A_W    = fdi_pkg::ACC_W;
   localparam int FRAC   = S - 1;
   localparam int RND_W  = A_W + 1;
   localparam int SHR_W  = RND_W - FRAC;
   localparam int BIAS   = 1 << (FRAC - 1);
   localparam logic signed [SHR_W-1:0] SAT_HI = SHR_W'((1 << FRAC) - 1);
   localparam logic signed [SHR_W-1:0] SAT_LO = SHR_W'(-(1 << FRAC));

   fdi_pkg::mac_ctl_type    s1_ff, s2_ff;
   logic signed [P_W-1:0]   prod_i_ff, prod_i_in, prod_q_ff, prod_q_in;
   logic signed [A_W-1:0]   acc_i_ff, acc_i_in, acc_q_ff, acc_q_in;
   logic                    done_ff, done_in;

   // Round half up from Q2.30-style sum to Q1.15 and saturate
   function automatic logic signed [S-1:0] round_sat(input logic signed [A_W-1:0] acc);
      logic signed [RND_W-1:0] biased;
      logic signed [SHR_W-1:0] shifted;
      biased  = RND_W'(acc) + RND_W'(BIAS);
      shifted = SHR_W'(biased >>> FRAC);
      if (shifted > SAT_HI) begin
         return S'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         return S'(SAT_LO);
      end
      return S'(shifted);
   endfunction

   // Multiply stage, then accumulate stage
   always_comb begin
      prod_i_in = coef * hist_i;
      prod_q_in = coef * hist_q;
      acc_i_in  = acc_i_ff;
      acc_q_in  = acc_q_ff;
      if (s2_ff.valid) begin
         if (s2_ff.first) begin
            acc_i_in = A_W'(prod_i_ff);
            acc_q_in = A_W'(prod_q_ff);
         end else begin
            acc_i_in = acc_i_ff + A_W'(prod_i_ff);
            acc_q_in = acc_q_ff + A_W'(prod_q_ff);
         end
      end
      done_in = s2_ff.valid && s2_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         s2_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= ctl;
         s2_ff   <= s1_ff;
         done_ff <= done_in;
      end
      prod_i_ff <= prod_i_in;
      prod_q_ff <= prod_q_in;
      acc_i_ff  <= acc_i_in;
      acc_q_ff  <= acc_q_in;
   end

   assign done  = done_ff;
   assign res_i = round_sat(acc_i_ff);
   assign res_q = round_sat(acc_q_ff);

   // A new tap run never overlaps the tail of the previous one
   `FDI_ASSERT_IMPL(a_first_on_idle_pipe, clock, reset, ctl.valid && ctl.first, !s1_ff.valid && !s2_ff.valid && !done_ff, "tap run started while MAC pipeline busy")

endmodule

>>> design/fdi_seq.sv
`include "fir_decimator_iq_assert.svh"

module fdi_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fdi_pkg::cfg_type                      cfg,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fdi_pkg::CMD_W-1:0]             req_command,
   input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] req_sample_i,
   input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] req_sample_q,
   input  logic [fdi_pkg::TAP_SEL_W-1:0]         req_tap_index,
   input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] req_tap_value,
   output fdi_pkg::mem_req_type                  mem,
   output fdi_pkg::mac_ctl_type                  mac_ctl,
   input  logic                                  mac_done,
   input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] mac_res_i,
   input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] mac_res_q,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fdi_pkg::SAMPLE_BITS-1:0] rsp_out_i,
   output logic signed [fdi_pkg::SAMPLE_BITS-1:0] rsp_out_q
);

   localparam int S       = fdi_pkg::SAMPLE_BITS;
   localparam int IDX_W   = fdi_pkg::TAP_IDX_W;
   localparam int CNT_W   = fdi_pkg::TAP_CNT_W;
   localparam int PH_W    = fdi_pkg::PHASE_W;
   localparam int DCNT_W  = fdi_pkg::DECIM_CNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      wpos_ff, wpos_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [PH_W-1:0]       phase_ff, phase_in;
   logic [IDX_W-1:0]      tap_ff, tap_in;
   logic [IDX_W-1:0]      hidx_ff, hidx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [S-1:0]   out_i_ff, out_i_in, out_q_ff, out_q_in;

   logic [CNT_W-1:0]      ntaps, fill_clamp, fill_next, pos_inc;
   logic [IDX_W-1:0]      ntaps_m1, pos, wpos_next;
   logic [DCNT_W-1:0]     decim, phase_inc;
   logic [PH_W-1:0]       phase_next;
   logic                  accept, wrap, emit, out_free, load_out, last_tap;

   function automatic logic [CNT_W-1:0] taps_eff(input logic [fdi_pkg::TAPS_W-1:0] t);
      int unsigned v;
      v = t;
      if (v < 2) v = 2;
      if (v > fdi_pkg::MAX_TAPS) v = fdi_pkg::MAX_TAPS;
      return CNT_W'(v);
   endfunction

   function automatic logic [DCNT_W-1:0] decim_eff(input logic [fdi_pkg::DECIM_W-1:0] d);
      int unsigned v;
      v = d;
      if (v < 1) v = 1;
      if (v > fdi_pkg::DECIM_MAX) v = fdi_pkg::DECIM_MAX;
      return DCNT_W'(v);
   endfunction

   // Effective configuration
   assign ntaps    = taps_eff(cfg.taps_in_use);
   assign ntaps_m1 = IDX_W'(ntaps - CNT_W'(1));
   assign decim    = decim_eff(cfg.decimation_factor);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // History bookkeeping for a push
   assign pos        = (CNT_W'(wpos_ff) >= ntaps) ? '0 : wpos_ff;
   assign fill_clamp = (fill_ff > ntaps) ? ntaps : fill_ff;
   assign fill_next  = (fill_clamp < ntaps) ? fill_clamp + CNT_W'(1) : fill_clamp;
   assign phase_inc  = DCNT_W'(phase_ff) + DCNT_W'(1);
   assign wrap       = (phase_inc >= decim);
   assign phase_next = wrap ? '0 : PH_W'(phase_inc);
   assign emit       = wrap && (fill_next == ntaps);
   assign pos_inc    = CNT_W'(pos) + CNT_W'(1);
   assign wpos_next  = (pos_inc >= ntaps) ? '0 : IDX_W'(pos_inc);

   // Output register frees when empty or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = out_free && ((state_ff == ST_DRAIN && mac_done) || state_ff == ST_HOLD);
   assign last_tap = (CNT_W'(tap_ff) == ntaps - CNT_W'(1));

   // Next state and memory requests
   always_comb begin
      state_in  = state_ff;
      wpos_in   = wpos_ff;
      fill_in   = fill_ff;
      phase_in  = phase_ff;
      tap_in    = tap_ff;
      hidx_in   = hidx_ff;
      mac_ctl   = '0;

      mem              = '0;
      mem.coef_waddr   = IDX_W'(req_tap_index);
      mem.coef_wdata   = req_tap_value;
      mem.hist_waddr   = pos;
      mem.hist_wdata_i = req_sample_i;
      mem.hist_wdata_q = req_sample_q;
      mem.coef_raddr   = tap_ff;
      mem.hist_raddr   = hidx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (fdi_pkg::cmd_type'(req_command))
                  fdi_pkg::CMD_PUSH: begin
                     mem.hist_we = 1'b1;
                     fill_in     = fill_next;
                     phase_in    = phase_next;
                     wpos_in     = wpos_next;
                     if (emit) begin
                        state_in = ST_RUN;
                        tap_in   = '0;
                        hidx_in  = pos;
                     end
                  end
                  fdi_pkg::CMD_LOAD_TAP: begin
                     mem.coef_we = (int'(req_tap_index) < fdi_pkg::MAX_TAPS);
                  end
                  fdi_pkg::CMD_RESTART: begin
                     fill_in  = '0;
                     phase_in = '0;
                     wpos_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // One tap read per cycle: coefficient k against k-th newest sample
         ST_RUN: begin
            mac_ctl.valid = 1'b1;
            mac_ctl.first = (tap_ff == '0);
            mac_ctl.last  = last_tap;
            if (last_tap) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in  = tap_ff + IDX_W'(1);
               hidx_in = (hidx_ff == '0) ? ntaps_m1 : hidx_ff - IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_i_in     = out_i_ff;
      out_q_in     = out_q_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         out_i_in     = mac_res_i;
         out_q_in     = cfg.iq_enable ? mac_res_q : '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         phase_ff     <= '0;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hidx_ff  <= hidx_in;
      out_i_ff <= out_i_in;
      out_q_ff <= out_q_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_i = out_i_ff;
   assign rsp_out_q = out_q_ff;

   // Sum completes only while waiting for it
   `FDI_ASSERT_NEVER(a_done_in_drain, clock, reset, mac_done && state_ff != ST_DRAIN, "MAC result arrived outside drain")
   // Holding a result means the output register is still occupied
   `FDI_ASSERT_IMPL(a_hold_output_full, clock, reset, state_ff == ST_HOLD, rsp_valid_ff, "holding result with empty output register")

endmodule

>>> design/fir_decimator_iq.sv
// Decimating FIR filter for real or I/Q samples in Q1.15. Items carry one
// command: push a sample, load one tap coefficient, or restart the history.
// A push that closes a decimation period with a full history starts a sum
// over N taps, N being taps_in_use held to 2..64, and the input stalls until
// the sum is through; other items do not stall it. The taps are summed one
// per cycle through a single read port on the coefficient memory and one on
// the history memory, followed by the RAM read, multiply and accumulate
// registers; rounding happens on the way into the output register. The
// result then sits in that register, so the next item is taken while it
// waits; if the previous result is still waiting there when a new sum
// completes, the input stalls until it is taken. Sums are rounded half up
// and saturated to Q1.15; out_q is zero in real mode. Coefficient and
// history memories are not cleared by reset and must be loaded before use.
module fir_decimator_iq (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fdi_pkg::CMD_W-1:0]             req_command,
   input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] req_sample_i,
   input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] req_sample_q,
   input  logic [fdi_pkg::TAP_SEL_W-1:0]         req_tap_index,
   input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] req_tap_value,
   // Result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [fdi_pkg::SAMPLE_BITS-1:0] rsp_out_i,
   output logic signed [fdi_pkg::SAMPLE_BITS-1:0] rsp_out_q,
   // Register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [3:0]                            paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   localparam int S     = fdi_pkg::SAMPLE_BITS;
   localparam int DEPTH = fdi_pkg::MAX_TAPS;

   logic [fdi_pkg::DECIM_W-1:0] decim_ff, decim_in;
   logic [fdi_pkg::TAPS_W-1:0]  taps_ff, taps_in;
   logic                        cplx_ff, cplx_in;
   logic                        csr_wr;
   fdi_pkg::reg_idx_type        csr_index;

   fdi_pkg::cfg_type     cfg;
   fdi_pkg::mem_req_type mem;
   fdi_pkg::mac_ctl_type mac_ctl;
   logic                 mac_done;
   logic signed [S-1:0]  mac_res_i, mac_res_q;
   logic signed [S-1:0]  coef_rd, hist_rd_i, hist_rd_q;
   logic [2*S-1:0]       hist_rd;

   // Register file
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_index = fdi_pkg::reg_idx_type'(paddr[3:2]);

   always_comb begin
      decim_in = decim_ff;
      taps_in  = taps_ff;
      cplx_in  = cplx_ff;
      if (csr_wr) begin
         unique case (csr_index)
            fdi_pkg::REG_DECIMATION: decim_in = pwdata[fdi_pkg::DECIM_W-1:0];
            fdi_pkg::REG_TAPS:       taps_in  = pwdata[fdi_pkg::TAPS_W-1:0];
            fdi_pkg::REG_IQ_ENABLE:  cplx_in  = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decim_ff <= fdi_pkg::DECIM_W'(1);
         taps_ff  <= fdi_pkg::TAPS_W'(64);
         cplx_ff  <= 1'b1;
      end else begin
         decim_ff <= decim_in;
         taps_ff  <= taps_in;
         cplx_ff  <= cplx_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         fdi_pkg::REG_DECIMATION: prdata = 32'(decim_ff);
         fdi_pkg::REG_TAPS:       prdata = 32'(taps_ff);
         fdi_pkg::REG_IQ_ENABLE:  prdata = 32'(cplx_ff);
         default:                 prdata = '0;
      endcase
   end

   assign cfg.decimation_factor = decim_ff;
   assign cfg.taps_in_use       = taps_ff;
   assign cfg.iq_enable         = cplx_ff;

   // Sequencer: bookkeeping, tap loop and output register
   fdi_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_sample_i  (req_sample_i),
      .req_sample_q  (req_sample_q),
      .req_tap_index (req_tap_index),
      .req_tap_value (req_tap_value),
      .mem           (mem),
      .mac_ctl       (mac_ctl),
      .mac_done      (mac_done),
      .mac_res_i     (mac_res_i),
      .mac_res_q     (mac_res_q),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_i     (rsp_out_i),
      .rsp_out_q     (rsp_out_q)
   );

   // Coefficient memory
   fdi_ram #(
      .WIDTH (S),
      .DEPTH (DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (mem.coef_we),
      .wr_addr (mem.coef_waddr),
      .wr_data (mem.coef_wdata),
      .rd_addr (mem.coef_raddr),
      .rd_data (coef_rd)
   );

   // Circular history, I and Q side by side
   fdi_ram #(
      .WIDTH (2 * S),
      .DEPTH (DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (mem.hist_we),
      .wr_addr (mem.hist_waddr),
      .wr_data ({mem.hist_wdata_i, mem.hist_wdata_q}),
      .rd_addr (mem.hist_raddr),
      .rd_data (hist_rd)
   );

   assign hist_rd_i = hist_rd[2*S-1:S];
   assign hist_rd_q = hist_rd[S-1:0];

   // Multiply-accumulate and rounding
   fdi_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .coef   (coef_rd),
      .hist_i (hist_rd_i),
      .hist_q (hist_rd_q),
      .done   (mac_done),
      .res_i  (mac_res_i),
      .res_q  (mac_res_q)
   );

endmodule
